// ===== hdl/lz77te_pkg.sv =====
`default_nettype none
package lz77te_pkg;

  localparam int unsigned WindowDepthDef = 2048;
  localparam int unsigned MatchLimitDef  = 18;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } item_t;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StRead,
    StCmp,
    StFetch,
    StEmit
  } eng_state_e;

endpackage
`default_nettype wire

// ===== hdl/lz77te_front.sv =====
`default_nettype none
module lz77te_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            final_byte_i,
  output logic                 q_valid_o,
  input  wire logic            q_ready_i,
  output lz77te_pkg::item_t    q_item_o
);
  import lz77te_pkg::*;

  // two-entry queue between request port and engine
  item_t      slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= '{data: data_byte_i, fin: final_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lz77te_back.sv =====
`default_nettype none
module lz77te_back #(
  parameter int unsigned WINDOW_DEPTH = lz77te_pkg::WindowDepthDef,
  parameter int unsigned MATCH_LIMIT  = lz77te_pkg::MatchLimitDef,
  localparam int unsigned OffW = $clog2(WINDOW_DEPTH + 1),
  localparam int unsigned LenW = $clog2(MATCH_LIMIT + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  output logic                    q_ready_o,
  input  wire lz77te_pkg::item_t  q_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [OffW-1:0]         match_offset_o,
  output logic [LenW-1:0]         match_length_o,
  output logic [7:0]              next_byte_o,
  output logic                    run_last_o,
  output logic                    stream_end_o
);
  import lz77te_pkg::*;

  localparam int unsigned LookDepth = MATCH_LIMIT + 1;
  localparam int unsigned CntW      = $clog2(LookDepth + 1);
  localparam int unsigned MemAw     = $clog2(WINDOW_DEPTH + LookDepth);
  localparam int unsigned MemDepth  = 2 ** MemAw;

  // history and lookahead share one ring: lookahead sits just past the write pointer
  logic [7:0] mem_q [MemDepth];
  logic [7:0] rd_a_q, rd_b_q;
  logic [MemAw-1:0] addr_a, addr_b, addr_w;
  logic             we;

  eng_state_e       state_q, state_d;
  logic [MemAw-1:0] wr_q, wr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [OffW-1:0]  fill_q, fill_d;
  logic             fin_q, fin_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [LenW-1:0]  m_q, m_d;
  logic [LenW-1:0]  cap_q, cap_d;
  logic [LenW-1:0]  best_q, best_d;
  logic [OffW-1:0]  boff_q, boff_d;

  logic             ov_q, ov_d;
  logic [OffW-1:0]  oo_q, oo_d;
  logic [LenW-1:0]  ol_q, ol_d;
  logic [7:0]       ob_q, ob_d;
  logic             orl_q, orl_d, oe_q, oe_d;

  logic [LenW-1:0]  m_end;
  logic [LenW-1:0]  best_new;
  logic [CntW-1:0]  used;
  logic [OffW:0]    fill_sum;

  assign out_valid_o    = ov_q;
  assign match_offset_o = oo_q;
  assign match_length_o = ol_q;
  assign next_byte_o    = ob_q;
  assign run_last_o     = orl_q;
  assign stream_end_o   = oe_q;

  assign used     = CntW'(best_q) + CntW'(1);
  assign fill_sum = (OffW+1)'(fill_q) + (OffW+1)'(used);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr_w] <= q_item_i.data;
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
  end

  always_comb begin
    state_d = state_q;
    wr_d    = wr_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    fin_d   = fin_q;
    off_d   = off_q;
    m_d     = m_q;
    cap_d   = cap_q;
    best_d  = best_q;
    boff_d  = boff_q;
    ov_d    = ov_q && !out_ready_i;
    oo_d    = oo_q;
    ol_d    = ol_q;
    ob_d    = ob_q;
    orl_d   = orl_q;
    oe_d    = oe_q;
    q_ready_o = 1'b0;
    we      = 1'b0;
    addr_w  = wr_q + MemAw'(cnt_q);
    addr_a  = wr_q + MemAw'(best_q);
    addr_b  = wr_q - MemAw'(off_q) + MemAw'(m_q);
    m_end   = m_q;
    best_new = best_q;

    unique case (state_q)
      StIdle: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          we    = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          fin_d = q_item_i.fin;
          if (q_item_i.fin || (cnt_q + CntW'(1) == CntW'(LookDepth))) begin
            state_d = StStart;
          end
        end
      end
      StStart: begin
        // match never takes the last held byte
        cap_d  = LenW'(cnt_q - CntW'(1));
        best_d = '0;
        boff_d = '0;
        off_d  = OffW'(1);
        m_d    = '0;
        if (cnt_q == CntW'(1) || fill_q == '0) begin
          state_d = StFetch;
        end else begin
          state_d = StRead;
        end
      end
      StRead: begin
        addr_a  = wr_q + MemAw'(m_q);
        state_d = StCmp;
      end
      StCmp: begin
        if (rd_a_q == rd_b_q && m_q + LenW'(1) < cap_q) begin
          m_d     = m_q + LenW'(1);
          state_d = StRead;
        end else begin
          m_end = (rd_a_q == rd_b_q) ? m_q + LenW'(1) : m_q;
          if (m_end > best_q) begin
            best_new = m_end;
            boff_d   = off_q;
          end
          best_d = best_new;
          if (best_new == cap_q || off_q == fill_q) begin
            state_d = StFetch;
          end else begin
            off_d   = off_q + OffW'(1);
            m_d     = '0;
            state_d = StRead;
          end
        end
      end
      StFetch: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (!ov_q || out_ready_i) begin
          ov_d  = 1'b1;
          oo_d  = boff_q;
          ol_d  = best_q;
          ob_d  = rd_a_q;
          wr_d  = wr_q + MemAw'(used);
          cnt_d = cnt_q - used;
          if (fill_sum > (OffW+1)'(WINDOW_DEPTH)) begin
            fill_d = OffW'(WINDOW_DEPTH);
          end else begin
            fill_d = fill_sum[OffW-1:0];
          end
          if (!fin_q) begin
            orl_d   = 1'b1;
            oe_d    = 1'b0;
            state_d = StIdle;
          end else if (cnt_q == used) begin
            orl_d   = 1'b1;
            oe_d    = 1'b1;
            fill_d  = '0;
            cnt_d   = '0;
            state_d = StIdle;
          end else begin
            orl_d   = 1'b0;
            oe_d    = 1'b0;
            state_d = StStart;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wr_q    <= '0;
      cnt_q   <= '0;
      fill_q  <= '0;
      fin_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      fin_q   <= fin_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    m_q    <= m_d;
    cap_q  <= cap_d;
    best_q <= best_d;
    boff_q <= boff_d;
    oo_q   <= oo_d;
    ol_q   <= ol_d;
    ob_q   <= ob_d;
    orl_q  <= orl_d;
    oe_q   <= oe_d;
  end

endmodule
`default_nettype wire

// ===== hdl/lz77_triple_encoder_core.sv =====
`default_nettype none
// channel | handshake             | payload
// input   | in_valid_i/in_ready_o | data_byte_i, final_byte_i
// output  | out_valid_o/out_ready_i | match_offset_o, match_length_o, next_byte_o,
//         |                       |   run_last_o, stream_end_o
// a byte that causes no token is only written to the ring by the idle engine, after a two-entry queue
// a token passes StStart, then StRead and StCmp once per byte compared, then StFetch
// and StEmit; further tokens of a flush loop from StEmit back to StStart; the search
// walks offsets 1..fill one byte a step through the two read ports of the history
// ring, stopping an offset at its first mismatch and the search once the cap is reached
// reset clears the queue, counts and output valid flag; ring contents need no clearing
// a stalled output holds the engine; the queue keeps taking requests until full
module lz77_triple_encoder_core #(
  parameter int unsigned WINDOW_DEPTH = lz77te_pkg::WindowDepthDef,
  parameter int unsigned MATCH_LIMIT  = lz77te_pkg::MatchLimitDef,
  localparam int unsigned OffW = $clog2(WINDOW_DEPTH + 1),
  localparam int unsigned LenW = $clog2(MATCH_LIMIT + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            final_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [OffW-1:0]      match_offset_o,
  output logic [LenW-1:0]      match_length_o,
  output logic [7:0]           next_byte_o,
  output logic                 run_last_o,
  output logic                 stream_end_o
);
  import lz77te_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;

  lz77te_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .final_byte_i(final_byte_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  lz77te_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .MATCH_LIMIT (MATCH_LIMIT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_item_i      (q_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_offset_o(match_offset_o),
    .match_length_o(match_length_o),
    .next_byte_o   (next_byte_o),
    .run_last_o    (run_last_o),
    .stream_end_o  (stream_end_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/lz77_triple_encoder_checker.sv =====
`timescale 1ns / 100ps
module lz77_triple_encoder_checker #(
  parameter int unsigned WINDOW_DEPTH = lz77te_pkg::WindowDepthDef,
  parameter int unsigned MATCH_LIMIT  = lz77te_pkg::MatchLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [11:0] match_offset_i,
  input  logic [4:0]  match_length_i,
  input  logic [7:0]  next_byte_i,
  input  logic        run_last_i,
  input  logic        stream_end_i,
  output int          pending_o,
  output int          fail_count_o
);

  localparam int unsigned LookDepth = MATCH_LIMIT + 1;

  typedef struct {
    logic [11:0] offset;
    logic [4:0]  length;
    logic [7:0]  nbyte;
    logic        run_last;
    logic        stream_end;
  } triple_t;

  triple_t     token_q[$];
  logic [7:0]  window_mem[WINDOW_DEPTH];
  int unsigned win_wr;
  int unsigned win_fill;
  logic [7:0]  look_mem[LookDepth];
  int unsigned look_cnt;
  int          fails;

  assign pending_o    = token_q.size();
  assign fail_count_o = fails;

  function automatic void push_window(logic [7:0] b);
    window_mem[win_wr] = b;
    win_wr = (win_wr + 1) % WINDOW_DEPTH;
    if (win_fill < WINDOW_DEPTH) win_fill++;
  endfunction

  // longest match, smallest offset on ties; match may run into the lookahead
  function automatic void encode_triple();
    int unsigned cap, best_len, best_off, m;
    logic [7:0]  b;
    triple_t     t;
    cap      = look_cnt - 1;
    best_len = 0;
    best_off = 0;
    if (cap > MATCH_LIMIT) cap = MATCH_LIMIT;
    for (int unsigned i = 1; i <= win_fill; i++) begin
      m = 0;
      while (m < cap) begin
        b = (m < i) ? window_mem[(win_wr + WINDOW_DEPTH - (i - m)) % WINDOW_DEPTH]
                    : look_mem[m - i];
        if (b != look_mem[m]) break;
        m++;
      end
      if (m > best_len) begin
        best_len = m;
        best_off = i;
      end
    end
    t.offset     = best_off[11:0];
    t.length     = best_len[4:0];
    t.nbyte      = look_mem[best_len];
    t.run_last   = 1'b0;
    t.stream_end = 1'b0;
    token_q = {token_q, t};
    for (int unsigned k = 0; k <= best_len; k++) push_window(look_mem[k]);
    for (int unsigned k = 0; k + best_len + 1 < look_cnt; k++)
      look_mem[k] = look_mem[k + best_len + 1];
    look_cnt -= best_len + 1;
  endfunction

  function automatic void take_byte(logic [7:0] d, logic fin);
    if (look_cnt < LookDepth) begin
      look_mem[look_cnt] = d;
      look_cnt++;
    end
    if (fin) begin
      while (look_cnt > 0) encode_triple();
      token_q[token_q.size() - 1].run_last   = 1'b1;
      token_q[token_q.size() - 1].stream_end = 1'b1;
      win_wr   = 0;
      win_fill = 0;
      look_cnt = 0;
    end else if (look_cnt == LookDepth) begin
      encode_triple();
      token_q[token_q.size() - 1].run_last = 1'b1;
    end
  endfunction

  initial begin
    fails    = 0;
    win_wr   = 0;
    win_fill = 0;
    look_cnt = 0;
  end

  always @(posedge clk_i) begin
    triple_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) take_byte(data_byte_i, final_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (token_q.size() == 0) begin
          $error("unexpected token: offset %0d length %0d byte %0h",
                 match_offset_i, match_length_i, next_byte_i);
          fails++;
        end else begin
          e = token_q.pop_front();
          if (match_offset_i !== e.offset) begin
            $error("match_offset: expected %0d, got %0d", e.offset, match_offset_i);
            fails++;
          end
          if (match_length_i !== e.length) begin
            $error("match_length: expected %0d, got %0d", e.length, match_length_i);
            fails++;
          end
          if (next_byte_i !== e.nbyte) begin
            $error("next_byte: expected %0h, got %0h", e.nbyte, next_byte_i);
            fails++;
          end
          if (run_last_i !== e.run_last) begin
            $error("run_last: expected %0b, got %0b", e.run_last, run_last_i);
            fails++;
          end
          if (stream_end_i !== e.stream_end) begin
            $error("stream_end: expected %0b, got %0b", e.stream_end, stream_end_i);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/lz77_triple_encoder_core_tb.sv =====
`timescale 1ns / 100ps
module lz77_triple_encoder_core_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] match_offset_o;
  logic [4:0]  match_length_o;
  logic [7:0]  next_byte_o;
  logic        run_last_o;
  logic        stream_end_o;
  int          pending;
  int          fail_count;
  int          sent;
  bit          no_stall;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lz77_triple_encoder_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .final_byte_i,
    .out_valid_o, .out_ready_i, .match_offset_o, .match_length_o, .next_byte_o,
    .run_last_o, .stream_end_o
  );

  lz77_triple_encoder_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i,
    .final_byte_i, .out_valid_i(out_valid_o), .out_ready_i,
    .match_offset_i(match_offset_o), .match_length_i(match_length_o),
    .next_byte_i(next_byte_o), .run_last_i(run_last_o), .stream_end_i(stream_end_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  task automatic send_request(logic [7:0] d, logic fin);
    int unsigned gap;
    bit          rdy;
    gap = no_stall ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= d;
    final_byte_i <= fin;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    sent++;
  endtask

  task automatic send_stream(int unsigned len);
    logic [7:0]  alpha[4];
    logic [7:0]  buffer[$];
    logic [7:0]  d;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    foreach (alpha[j]) alpha[j] = 8'($urandom_range(0, 255));
    for (int unsigned k = 0; k < len; k++) begin
      if (mode < 6) d = alpha[$urandom_range(0, 3)];
      else if (mode < 8 && buffer.size() > 0 && $urandom_range(0, 3) != 0)
        d = buffer[$urandom_range(0, buffer.size() - 1)];
      else d = 8'($urandom_range(0, 255));
      buffer = {buffer, d};
      send_request(d, k == len - 1);
    end
  endtask

  // output side: random stall before each token, with stall-free stretches
  initial begin
    int unsigned stall;
    bit          vld;
    @(posedge rst_ni);
    forever begin
      stall = no_stall ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        vld = out_valid_o;
        @(posedge clk_i);
      end while (!vld);
    end
  end

  initial begin
    #100ms;
    $display("lz77_triple_encoder_core regression: fail");
    $finish;
  end

  initial begin
    sent     = 0;
    no_stall = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // single literal flushed at once
    send_request(8'h00, 1'b1);
    // run of one value: full lookahead, overlapping matches, capped flush
    for (int k = 0; k < 22; k++) send_request(8'hFF, k == 21);
    while (sent < 345) begin
      no_stall = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) send_stream($urandom_range(41, 150));
      else send_stream($urandom_range(1, 40));
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("lz77_triple_encoder_core regression: pass");
    else $display("lz77_triple_encoder_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lz77te_pkg.sv
hdl/lz77te_front.sv
hdl/lz77te_back.sv
hdl/lz77_triple_encoder_core.sv
tb/sv/lz77_triple_encoder_checker.sv
tb/sv/lz77_triple_encoder_core_tb.sv
